[rtl/wsd_pkg.sv]
// Package with the types and constants shared by the WebSocket deframer modules.
`timescale 1ns / 1ps

package wsd_pkg;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  // Opcode of a close frame.
  localparam logic [6:0] CLOSE_OP = 7'h08;

  // Number of extended length bytes for each length form.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Number of mask key bytes in every frame.
  localparam logic [2:0] KEY_BYTES = 3'd4;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXT    = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CLOSED = 3'd5
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  // One result item as it travels from the parser to the output register.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [6:0] frame_opcode;
    logic       last;
  } result_t;

endpackage

[rtl/wsd_parser.sv]
// Frame parser: header, length, mask key and payload state, one byte per step.
`timescale 1ns / 1ps

module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  output logic             emit_o,
  output wsd_pkg::result_t result_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [6:0]  opcode_q, opcode_d;
  logic [63:0] length_q, length_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  idx_q, idx_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  key_left_q, key_left_d;

  logic [6:0] len7;
  logic [7:0] key_byte;

  assign len7 = rx_byte_i[6:0];

  // Key byte for the current payload position, first received byte first.
  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state and the result of the current byte.
  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    length_d   = length_q;
    remain_d   = remain_q;
    idx_d      = idx_q;
    ext_left_d = ext_left_q;
    key_d      = key_q;
    key_left_d = key_left_q;

    emit_o                = 1'b0;
    result_o.kind         = wsd_pkg::KIND_DATA;
    result_o.data_byte    = 8'd0;
    result_o.frame_opcode = opcode_q;
    result_o.last         = 1'b1;

    unique case (phase_q)
      wsd_pkg::PH_HDR1: begin
        if (opcode_q == wsd_pkg::CLOSE_OP) begin
          phase_d       = wsd_pkg::PH_CLOSED;
          emit_o        = 1'b1;
          result_o.kind = wsd_pkg::KIND_CLOSE;
        end else if (len7 == wsd_pkg::LEN16_CODE) begin
          length_d   = '0;
          ext_left_d = wsd_pkg::EXT16_BYTES;
          phase_d    = wsd_pkg::PH_EXT;
        end else if (len7 == wsd_pkg::LEN64_CODE) begin
          length_d   = '0;
          ext_left_d = wsd_pkg::EXT64_BYTES;
          phase_d    = wsd_pkg::PH_EXT;
        end else begin
          length_d   = {57'd0, len7};
          key_left_d = wsd_pkg::KEY_BYTES;
          phase_d    = wsd_pkg::PH_KEY;
        end
      end
      wsd_pkg::PH_EXT: begin
        length_d   = {length_q[55:0], rx_byte_i};
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_q == 4'd1) begin
          key_left_d = wsd_pkg::KEY_BYTES;
          phase_d    = wsd_pkg::PH_KEY;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_d      = {key_q[23:0], rx_byte_i};
        key_left_d = key_left_q - 3'd1;
        if (key_left_q == 3'd1) begin
          idx_d    = 2'd0;
          remain_d = length_q;
          if (length_q == 64'd0) begin
            phase_d       = wsd_pkg::PH_HDR0;
            emit_o        = 1'b1;
            result_o.kind = wsd_pkg::KIND_EMPTY;
          end else begin
            phase_d = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_DATA: begin
        // A down-counter of the bytes still to come marks the last payload byte.
        idx_d              = idx_q + 2'd1;
        remain_d           = remain_q - 64'd1;
        emit_o             = 1'b1;
        result_o.data_byte = rx_byte_i ^ key_byte;
        result_o.last      = (remain_q == 64'd1);
        if (remain_q == 64'd1) begin
          phase_d = wsd_pkg::PH_HDR0;
        end
      end
      wsd_pkg::PH_CLOSED: begin
        // Everything after a close frame is dropped until reset.
      end
      default: begin
        opcode_d = rx_byte_i[6:0];
        phase_d  = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  // State registers, updated only when a byte is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wsd_pkg::PH_HDR0;
      opcode_q   <= '0;
      length_q   <= '0;
      remain_q   <= '0;
      idx_q      <= '0;
      ext_left_q <= '0;
      key_q      <= '0;
      key_left_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      length_q   <= length_d;
      remain_q   <= remain_d;
      idx_q      <= idx_d;
      ext_left_q <= ext_left_d;
      key_q      <= key_d;
      key_left_q <= key_left_d;
    end
  end

endmodule

[rtl/websocket_frame_deframer.sv]
// Top level of the WebSocket frame deframer: input register, parser and result register.
// An accepted byte is held in the input register, and its result then in the result register.
// Throughput: one byte per cycle while the output is not held; the parser state steps once per byte.
// The input register and the result register let a byte be taken while a result waits.
// Reset is asynchronous and active low; it returns the parser to the first header byte
// and clears the close condition, the length, the counters and the mask key.
`timescale 1ns / 1ps

module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [6:0] frame_opcode_o,
  output logic       last_o
);

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             out_valid_q;
  wsd_pkg::result_t result_q;
  wsd_pkg::result_t result;
  logic             emit;
  logic             step;

  // A buffered item moves on when the result register is free or being emptied.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (byte_q),
    .emit_o    (emit),
    .result_o  (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      result_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = result_q.kind;
  assign data_byte_o    = result_q.data_byte;
  assign frame_opcode_o = result_q.frame_opcode;
  assign last_o         = result_q.last;

endmodule

[tb/websocket_frame_deframer_test.sv]
// Self-checking testbench for the WebSocket frame deframer with a built-in frame predictor.
`timescale 1ns / 1ps

module websocket_frame_deframer_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_BYTES = 250;

  // How a frame announces its payload length.
  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  // How the run ends: a close frame with or without FIN, or an endless frame.
  typedef enum int {
    TAIL_CLOSE_FIN,
    TAIL_CLOSE_NOFIN,
    TAIL_HUGE
  } tail_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_byte_o;
  logic [6:0] frame_opcode_o;
  logic       last_o;

  // Bytes waiting to be offered, and the results predicted for accepted bytes.
  logic [7:0]       rx_stream_q[$];
  wsd_pkg::result_t deframed_q[$];
  wsd_pkg::result_t oldest;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Predictor state.
  wsd_pkg::phase_e ph = wsd_pkg::PH_HDR0;
  logic [6:0]  opcode_reg = '0;
  logic [63:0] frame_length = '0;
  logic [63:0] bytes_done = '0;
  logic [3:0]  ext_left = '0;
  logic [31:0] key_word = '0;
  logic [2:0]  key_left = '0;

  websocket_frame_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .frame_opcode_o(frame_opcode_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Step the frame parser by one received byte and queue the result it gives.
  function automatic void deframe_byte(input logic [7:0] b);
    wsd_pkg::result_t r;
    logic [7:0]       key_byte;
    r.kind = wsd_pkg::KIND_DATA;
    r.data_byte = 8'h00;
    r.frame_opcode = opcode_reg;
    r.last = 1'b1;
    case (ph)
      wsd_pkg::PH_HDR1: begin
        if (opcode_reg == wsd_pkg::CLOSE_OP) begin
          ph = wsd_pkg::PH_CLOSED;
          r.kind = wsd_pkg::KIND_CLOSE;
          deframed_q.push_back(r);
        end else begin
          frame_length = '0;
          if (b[6:0] == wsd_pkg::LEN16_CODE) begin
            ext_left = wsd_pkg::EXT16_BYTES;
            ph = wsd_pkg::PH_EXT;
          end else if (b[6:0] == wsd_pkg::LEN64_CODE) begin
            ext_left = wsd_pkg::EXT64_BYTES;
            ph = wsd_pkg::PH_EXT;
          end else begin
            frame_length = 64'(b[6:0]);
            key_left = wsd_pkg::KEY_BYTES;
            ph = wsd_pkg::PH_KEY;
          end
        end
      end
      wsd_pkg::PH_EXT: begin
        frame_length = {frame_length[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) begin
          key_left = wsd_pkg::KEY_BYTES;
          ph = wsd_pkg::PH_KEY;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_word = {key_word[23:0], b};
        key_left = key_left - 3'd1;
        if (key_left == 3'd0) begin
          bytes_done = '0;
          if (frame_length == 64'd0) begin
            ph = wsd_pkg::PH_HDR0;
            r.kind = wsd_pkg::KIND_EMPTY;
            deframed_q.push_back(r);
          end else begin
            ph = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_DATA: begin
        key_byte = 8'(key_word >> (24 - 8 * int'(bytes_done[1:0])));
        bytes_done = bytes_done + 64'd1;
        r.last = (bytes_done == frame_length);
        if (r.last) begin
          ph = wsd_pkg::PH_HDR0;
        end
        r.data_byte = b ^ key_byte;
        deframed_q.push_back(r);
      end
      wsd_pkg::PH_CLOSED: begin
        // Everything after a close frame is dropped.
      end
      default: begin
        opcode_reg = b[6:0];
        ph = wsd_pkg::PH_HDR1;
      end
    endcase
  endfunction

  // Queue one frame: header, length, random mask key and payload_cnt random payload bytes.
  task automatic queue_frame(input logic [7:0] hdr0, input logic mask_bit,
                             input logic [63:0] len, input len_form_e form,
                             input int payload_cnt);
    rx_stream_q.push_back(hdr0);
    case (form)
      LEN_EXT16: begin
        rx_stream_q.push_back({mask_bit, wsd_pkg::LEN16_CODE});
        rx_stream_q.push_back(len[15:8]);
        rx_stream_q.push_back(len[7:0]);
      end
      LEN_EXT64: begin
        rx_stream_q.push_back({mask_bit, wsd_pkg::LEN64_CODE});
        for (int i = 7; i >= 0; i--) begin
          rx_stream_q.push_back(len[8 * i +: 8]);
        end
      end
      default: begin
        rx_stream_q.push_back({mask_bit, len[6:0]});
      end
    endcase
    for (int i = 0; i < 4 + payload_cnt; i++) begin
      rx_stream_q.push_back(8'($urandom));
    end
  endtask

  // Queue random non-close frames until about n_bytes bytes have been added.
  task automatic queue_random_frames(input int n_bytes);
    int          start_size;
    int          sel;
    logic [6:0]  op;
    logic [63:0] len;
    len_form_e   form;
    start_size = rx_stream_q.size();
    while (rx_stream_q.size() - start_size < n_bytes) begin
      do begin
        op = 7'($urandom_range(0, 127));
      end while (op == wsd_pkg::CLOSE_OP);
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        form = LEN_SHORT;
        len = 64'($urandom_range(120, 125));
      end else if (sel < 70) begin
        form = LEN_SHORT;
        len = 64'($urandom_range(0, 12));
      end else if (sel < 85) begin
        form = LEN_EXT16;
        len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300))
                                          : 64'($urandom_range(0, 30));
      end else begin
        form = LEN_EXT64;
        len = 64'($urandom_range(0, 30));
      end
      queue_frame({1'($urandom_range(0, 1)), op}, 1'($urandom_range(0, 1)), len, form,
                  int'(len));
    end
  endtask

  // Hold the stimulus until every byte is accepted and every result has come back.
  task automatic drain();
    while (rx_stream_q.size() != 0 || in_valid || deframed_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Sender: predict each accepted item and offer the next byte unless idling.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        deframe_byte(rx_byte);
      end
      if (!in_valid || in_ready_o) begin
        if (rx_stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rx_byte  <= rx_stream_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each accepted result with the oldest prediction, then pick ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (deframed_q.size() == 0) begin
        $error("unexpected result: kind %0d data 0x%02h opcode 0x%02h last %0d",
               kind_o, data_byte_o, frame_opcode_o, last_o);
        error_count++;
      end else begin
        oldest = deframed_q.pop_front();
        if (kind_o !== oldest.kind) begin
          $error("kind: expected %0d, got %0d", oldest.kind, kind_o);
          error_count++;
        end
        if (data_byte_o !== oldest.data_byte) begin
          $error("data_byte: expected 0x%02h, got 0x%02h", oldest.data_byte, data_byte_o);
          error_count++;
        end
        if (frame_opcode_o !== oldest.frame_opcode) begin
          $error("frame_opcode: expected 0x%02h, got 0x%02h", oldest.frame_opcode,
                 frame_opcode_o);
          error_count++;
        end
        if (last_o !== oldest.last) begin
          $error("last: expected %0d, got %0d", oldest.last, last_o);
          error_count++;
        end
      end
    end
    // A new hold request starts a long stretch with ready low.
    if (hold_seen != hold_req_cnt) begin
      hold_seen <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("websocket_frame_deframer_test: errors");
      $finish;
    end
  end

  // Stimulus: directed frames, random phases with different idling, then the final frame.
  initial begin
    tail_e tail;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero-length short frame, opcode and header extremes, zero-length 64-bit form.
    queue_frame(8'h00, 1'b1, 64'd0, LEN_SHORT, 0);
    queue_frame(8'hFF, 1'b0, 64'd1, LEN_SHORT, 1);
    queue_frame(8'h09, 1'b1, 64'd0, LEN_EXT64, 0);

    // No idling; a long receiver hold-off makes the block fill and stall its input.
    queue_random_frames(PHASE_BYTES);
    hold_req_cnt = hold_req_cnt + 1;
    drain();

    send_idle_pct = 72;
    recv_stall_pct = 0;
    queue_random_frames(PHASE_BYTES);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 72;
    queue_random_frames(PHASE_BYTES);
    drain();

    send_idle_pct = 11;
    recv_stall_pct = 11;
    queue_random_frames(PHASE_BYTES);

    // A close frame or a frame with a huge length ends the useful stream.
    tail = tail_e'($urandom_range(0, 2));
    case (tail)
      TAIL_CLOSE_FIN, TAIL_CLOSE_NOFIN: begin
        rx_stream_q.push_back({tail == TAIL_CLOSE_FIN, wsd_pkg::CLOSE_OP});
        for (int i = 0; i < 12; i++) begin
          rx_stream_q.push_back(8'($urandom));
        end
      end
      default: begin
        queue_frame(8'h82, 1'b1, {1'b1, 31'($urandom), 32'($urandom)}, LEN_EXT64, 20);
      end
    endcase
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("websocket_frame_deframer_test: clean");
    end else begin
      $display("websocket_frame_deframer_test: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
tb/websocket_frame_deframer_test.sv
